FILE: rtl/core/frame_reassembly_slot_manager_unit_macros.svh
// assertion macros for the frame reassembly slot manager checker
// needs aclk and aresetn in the scope where a macro is used
`ifndef FRAME_REASSEMBLY_SLOT_MANAGER_UNIT_MACROS_SVH
`define FRAME_REASSEMBLY_SLOT_MANAGER_UNIT_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define FRSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define FRSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/frsm_pkg.sv
// shared constants, codes and types of the frame reassembly slot manager
// no dependencies
`default_nettype none

package frsm_pkg;

    // sizing
    localparam int NUM_SLOTS    = 8;
    localparam int MAX_SECTIONS = 1024;
    localparam int SLOT_BYTES   = 1048576;
    localparam int HEADER_BYTES = 8;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
    localparam int OFFS_W = SEC_W + 16;
    localparam int PROD_W = LEN_W + 10;

    localparam int PERMILLE_FULL = 1000;

    // stream widths
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 56;

    // request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // event codes
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_WRITE     = 3'd1;
    localparam logic [2:0] EV_PUSH_FULL = 3'd2;
    localparam logic [2:0] EV_PUSH_PART = 3'd3;
    localparam logic [2:0] EV_RELEASE   = 3'd4;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SECTION_BYTES = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LARGE_THR     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_TO       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REASM_TO      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_GAP     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALLOW_PART    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERMILLE      = 3'd6;

    typedef struct packed {
        logic [15:0]        spb;
        logic [20:0]        large_thr;
        logic [31:0]        sync_to;
        logic [31:0]        reasm_to;
        logic signed [15:0] gap;
        logic               allow_part;
        logic [9:0]         permille;
    } cfg_t;

    // classified request handed from front to back
    typedef struct packed {
        logic             tick;
        logic             drop;
        logic [15:0]      frame;
        logic [SEC_W-1:0] sec;
        logic             sec_ok;
        logic [LEN_W-1:0] flen;
        logic [15:0]      payload;
        logic             buf_ok;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [15:0] frame;
        logic [19:0] offset;
        logic [15:0] length;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/frsm_front.sv
// front end: unpacks an input request and classifies it for the back end
// depends on frsm_pkg
`default_nettype none

module frsm_front (
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // frame_index, section_index, frame_length, packet_length, buffer_available
    input  logic [frsm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // cmd
    input  logic                                s_axis_tuser,
    input  logic                                q_full,
    output logic                                q_push,
    output frsm_pkg::item_t                     q_item
);

    logic [15:0] sec16;
    logic [31:0] flen32;
    logic [15:0] plen;

    // field unpack
    assign sec16  = s_axis_tdata[31:16];
    assign flen32 = s_axis_tdata[63:32];
    assign plen   = s_axis_tdata[79:64];

    // classification
    always_comb begin
        q_item.tick    = s_axis_tuser;
        q_item.drop    = (plen < 16'(frsm_pkg::HEADER_BYTES)) ||
                         (flen32 > 32'(frsm_pkg::SLOT_BYTES));
        q_item.frame   = s_axis_tdata[15:0];
        q_item.sec     = sec16[frsm_pkg::SEC_W-1:0];
        q_item.payload = plen - 16'(frsm_pkg::HEADER_BYTES);
        q_item.sec_ok  = (32'(sec16) < 32'(frsm_pkg::MAX_SECTIONS)) && (q_item.payload != 16'd0);
        q_item.flen    = flen32[frsm_pkg::LEN_W-1:0];
        q_item.buf_ok  = s_axis_tdata[80];
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

endmodule

`default_nettype wire

FILE: rtl/core/frsm_queue.sv
// short request queue between front and back end
// depends on frsm_pkg
`default_nettype none

module frsm_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  frsm_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output frsm_pkg::item_t pop_item
);

    frsm_pkg::item_t                 entry_reg [frsm_pkg::QDEPTH];
    logic [frsm_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [frsm_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [frsm_pkg::QPTR_W:0]       count_reg;

    assign full     = (count_reg == (frsm_pkg::QPTR_W+1)'(frsm_pkg::QDEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && valid) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop && valid})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/frsm_back.sv
// back end: slot sequencer, slot table and section bitmap memory
// depends on frsm_pkg
`default_nettype none

module frsm_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  frsm_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  frsm_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              push_valid,
    output frsm_pkg::result_t push_res,
    input  logic              push_ready
);

    localparam int SW = frsm_pkg::SLOT_W;
    localparam int LW = frsm_pkg::LEN_W;
    localparam int NS = frsm_pkg::NUM_SLOTS;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RESYNC = 4'd1;
    localparam logic [3:0] ST_FIND   = 4'd2;
    localparam logic [3:0] ST_PICK   = 4'd3;
    localparam logic [3:0] ST_ALLOC  = 4'd4;
    localparam logic [3:0] ST_RDROW  = 4'd5;
    localparam logic [3:0] ST_CHECK  = 4'd6;
    localparam logic [3:0] ST_PUSHF  = 4'd7;
    localparam logic [3:0] ST_SCAN_A = 4'd8;
    localparam logic [3:0] ST_SCAN_B = 4'd9;
    localparam logic [3:0] ST_FIN    = 4'd10;

    logic [3:0]              state_reg;
    logic [SW-1:0]           idx_reg;
    logic [SW-1:0]           tgt_reg;
    frsm_pkg::item_t         item_reg;
    logic                    in_sync_reg;
    logic [15:0]             lpf_reg;
    logic [31:0]             lat_reg;
    logic [31:0]             tick_reg;
    logic [NS-1:0]           busy_reg;
    logic [NS-1:0]           rowv_reg;
    logic [15:0]             sframe_reg [NS];
    logic [31:0]             sstart_reg [NS];
    logic [LW-1:0]           slen_reg   [NS];
    logic [LW-1:0]           srcv_reg   [NS];

    logic [frsm_pkg::MAX_SECTIONS-1:0] seen_mem [NS];
    logic [frsm_pkg::MAX_SECTIONS-1:0] row_q;
    logic                              row_valid_q;

    logic                    match_v_reg, empty_v_reg, small_v_reg, large_v_reg;
    logic [SW-1:0]           match_s_reg, empty_s_reg, small_s_reg, large_s_reg;
    logic [31:0]             small_age_reg, large_age_reg;

    logic [frsm_pkg::OFFS_W-1:0] offset_reg;
    logic                        held_v_reg;
    frsm_pkg::result_t           held_reg;
    logic [frsm_pkg::PROD_W-1:0] prod_rcv_reg;
    logic [frsm_pkg::PROD_W-1:0] prod_len_reg;
    logic                        timed_out_reg;

    logic                    idx_last;
    logic                    busy_i;
    logic [31:0]             age_i;
    logic                    large_i;
    logic [15:0]             frame_i;
    logic [31:0]             tick_inc;
    logic                    sto_pkt, sto_tick;
    logic                    ins0, ins1, pkt_stale;
    logic [15:0]             diff;
    logic [15:0]             pdiff;
    logic                    part_ok;
    logic                    victim_v;
    logic [SW-1:0]           victim_s;
    logic [LW-1:0]           len_t, rcv_t, rcv_new;
    logic                    seen_t, reject, clip, completes;
    logic [32:0]             end_sum;
    logic [15:0]             pay_w;
    logic [frsm_pkg::MAX_SECTIONS-1:0] sec_bit, mem_wdata;
    logic                    mem_we;
    logic                    emit_req, fin_req, step_ok;
    frsm_pkg::result_t       emit_res;
    logic                    free_en;
    logic [SW-1:0]           free_s;

    // per-slot view at the scan index
    assign idx_last = (idx_reg == SW'(NS - 1));
    assign busy_i   = busy_reg[idx_reg];
    assign age_i    = tick_reg - sstart_reg[idx_reg];
    assign large_i  = 32'(slen_reg[idx_reg]) >= 32'(cfg.large_thr);
    assign frame_i  = sframe_reg[idx_reg];

    // sync checks at dispatch
    assign tick_inc  = tick_reg + 32'd1;
    assign sto_pkt   = (tick_reg - lat_reg) > cfg.sync_to;
    assign sto_tick  = (tick_inc - lat_reg) > cfg.sync_to;
    assign ins0      = in_sync_reg && !sto_pkt;
    assign diff      = q_item.frame - lpf_reg;
    assign ins1      = ins0 && !($signed(diff) < cfg.gap);
    assign pkt_stale = ins1 && ($signed(diff) <= 16'sd0);

    // partial push decision for a timed-out slot
    assign pdiff   = frame_i - lpf_reg;
    assign part_ok = cfg.allow_part && (prod_rcv_reg >= prod_len_reg) &&
                     ($signed(pdiff) > 16'sd0);

    // eviction victim: oldest small slot, else oldest large
    assign victim_v = !match_v_reg && !empty_v_reg && (small_v_reg || large_v_reg);
    assign victim_s = small_v_reg ? small_s_reg : large_s_reg;

    // section write checks on the target slot
    always_comb begin
        len_t     = slen_reg[tgt_reg];
        rcv_t     = srcv_reg[tgt_reg];
        seen_t    = row_valid_q && row_q[item_reg.sec];
        reject    = (rcv_t >= len_t) || !item_reg.sec_ok || seen_t ||
                    !(32'(offset_reg) < 32'(len_t));
        end_sum   = 33'(offset_reg) + 33'(item_reg.payload);
        clip      = end_sum > 33'(len_t);
        pay_w     = clip ? 16'(32'(len_t) - 32'(offset_reg)) : item_reg.payload;
        rcv_new   = rcv_t + LW'(pay_w);
        completes = rcv_new >= len_t;
        sec_bit   = '0;
        sec_bit[item_reg.sec] = 1'b1;
        mem_wdata = (row_valid_q ? row_q : '0) | sec_bit;
    end

    // result generation per state
    always_comb begin
        emit_req = 1'b0;
        fin_req  = 1'b0;
        emit_res = '0;
        free_en  = 1'b0;
        free_s   = idx_reg;
        case (state_reg)
            ST_RESYNC: begin
                emit_req       = busy_i;
                emit_res.kind  = frsm_pkg::EV_RELEASE;
                emit_res.slot  = 3'(idx_reg);
                emit_res.frame = frame_i;
                free_en        = busy_i;
            end
            ST_PICK: begin
                emit_req       = victim_v;
                emit_res.kind  = frsm_pkg::EV_RELEASE;
                emit_res.slot  = 3'(victim_s);
                emit_res.frame = sframe_reg[victim_s];
                free_en        = victim_v;
                free_s         = victim_s;
            end
            ST_CHECK: begin
                emit_req        = !reject;
                emit_res.kind   = frsm_pkg::EV_WRITE;
                emit_res.slot   = 3'(tgt_reg);
                emit_res.frame  = item_reg.frame;
                emit_res.offset = 20'(offset_reg);
                emit_res.length = pay_w;
            end
            ST_PUSHF: begin
                emit_req       = 1'b1;
                emit_res.kind  = frsm_pkg::EV_PUSH_FULL;
                emit_res.slot  = 3'(tgt_reg);
                emit_res.frame = item_reg.frame;
                free_en        = 1'b1;
                free_s         = tgt_reg;
            end
            ST_SCAN_B: begin
                emit_req       = timed_out_reg;
                emit_res.kind  = part_ok ? frsm_pkg::EV_PUSH_PART : frsm_pkg::EV_RELEASE;
                emit_res.slot  = 3'(idx_reg);
                emit_res.frame = frame_i;
                free_en        = timed_out_reg;
            end
            ST_FIN: begin
                fin_req = 1'b1;
            end
            default: begin
                emit_req = 1'b0;
            end
        endcase
    end

    // one result is held back so the final one can carry last
    always_comb begin
        push_valid    = (emit_req && held_v_reg) || fin_req;
        push_res      = held_v_reg ? held_reg : '0;
        push_res.last = fin_req;
        if (emit_req) begin
            step_ok = !held_v_reg || push_ready;
        end else if (fin_req) begin
            step_ok = push_ready;
        end else begin
            step_ok = 1'b1;
        end
    end

    assign q_pop  = (state_reg == ST_IDLE) && q_valid;
    assign mem_we = (state_reg == ST_CHECK) && step_ok && !reject && !completes;

    // section bitmap memory, one row per slot
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seen_mem[tgt_reg] <= mem_wdata;
        end
        row_q <= seen_mem[tgt_reg];
    end

    // sequencer and slot table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            in_sync_reg <= 1'b0;
            lpf_reg     <= '0;
            lat_reg     <= '0;
            tick_reg    <= '0;
            busy_reg    <= '0;
            rowv_reg    <= '0;
            held_v_reg  <= 1'b0;
            match_v_reg <= 1'b0;
            empty_v_reg <= 1'b0;
            small_v_reg <= 1'b0;
            large_v_reg <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                srcv_reg[i] <= '0;
            end
        end else begin
            row_valid_q <= rowv_reg[tgt_reg];
            if (step_ok) begin
                if (emit_req) begin
                    held_v_reg <= 1'b1;
                    held_reg   <= emit_res;
                end else if (fin_req) begin
                    held_v_reg <= 1'b0;
                end
                if (free_en) begin
                    busy_reg[free_s] <= 1'b0;
                    rowv_reg[free_s] <= 1'b0;
                    srcv_reg[free_s] <= '0;
                end
                case (state_reg)
                    ST_IDLE: begin
                        if (q_valid) begin
                            item_reg    <= q_item;
                            idx_reg     <= '0;
                            match_v_reg <= 1'b0;
                            empty_v_reg <= 1'b0;
                            small_v_reg <= 1'b0;
                            large_v_reg <= 1'b0;
                            if (q_item.tick) begin
                                tick_reg <= tick_inc;
                                if (in_sync_reg && sto_tick) begin
                                    in_sync_reg <= 1'b0;
                                end
                                state_reg <= ST_SCAN_A;
                            end else if (q_item.drop) begin
                                in_sync_reg <= ins0;
                                state_reg   <= ST_FIN;
                            end else if (pkt_stale) begin
                                in_sync_reg <= ins1;
                                state_reg   <= ST_FIN;
                            end else if (!ins1) begin
                                in_sync_reg <= 1'b1;
                                lpf_reg     <= q_item.frame - 16'd1;
                                lat_reg     <= tick_reg;
                                state_reg   <= ST_RESYNC;
                            end else begin
                                in_sync_reg <= 1'b1;
                                lat_reg     <= tick_reg;
                                state_reg   <= ST_FIND;
                            end
                        end
                    end
                    ST_RESYNC: begin
                        idx_reg   <= idx_last ? '0 : idx_reg + 1'b1;
                        state_reg <= idx_last ? ST_FIND : ST_RESYNC;
                    end
                    ST_FIND: begin
                        if (busy_i && (frame_i == item_reg.frame) && !match_v_reg) begin
                            match_v_reg <= 1'b1;
                            match_s_reg <= idx_reg;
                        end
                        if (!busy_i && !empty_v_reg) begin
                            empty_v_reg <= 1'b1;
                            empty_s_reg <= idx_reg;
                        end
                        if (busy_i && large_i && (!large_v_reg || age_i > large_age_reg)) begin
                            large_v_reg   <= 1'b1;
                            large_s_reg   <= idx_reg;
                            large_age_reg <= age_i;
                        end
                        if (busy_i && !large_i && (!small_v_reg || age_i > small_age_reg)) begin
                            small_v_reg   <= 1'b1;
                            small_s_reg   <= idx_reg;
                            small_age_reg <= age_i;
                        end
                        idx_reg   <= idx_last ? '0 : idx_reg + 1'b1;
                        state_reg <= idx_last ? ST_PICK : ST_FIND;
                    end
                    ST_PICK: begin
                        if (match_v_reg) begin
                            tgt_reg   <= match_s_reg;
                            state_reg <= ST_ALLOC;
                        end else if (empty_v_reg) begin
                            tgt_reg   <= empty_s_reg;
                            state_reg <= ST_ALLOC;
                        end else if (victim_v) begin
                            tgt_reg   <= victim_s;
                            state_reg <= ST_ALLOC;
                        end else begin
                            state_reg <= ST_FIN;
                        end
                    end
                    ST_ALLOC: begin
                        offset_reg <= frsm_pkg::OFFS_W'(frsm_pkg::OFFS_W'(item_reg.sec) *
                                                        frsm_pkg::OFFS_W'(cfg.spb));
                        if (!busy_reg[tgt_reg]) begin
                            if (!item_reg.buf_ok) begin
                                state_reg <= ST_FIN;
                            end else begin
                                busy_reg[tgt_reg]   <= 1'b1;
                                slen_reg[tgt_reg]   <= item_reg.flen;
                                sframe_reg[tgt_reg] <= item_reg.frame;
                                sstart_reg[tgt_reg] <= tick_reg;
                                srcv_reg[tgt_reg]   <= '0;
                                state_reg           <= ST_RDROW;
                            end
                        end else begin
                            state_reg <= ST_RDROW;
                        end
                    end
                    ST_RDROW: begin
                        state_reg <= ST_CHECK;
                    end
                    ST_CHECK: begin
                        if (reject) begin
                            state_reg <= ST_FIN;
                        end else begin
                            srcv_reg[tgt_reg] <= rcv_new;
                            if (completes) begin
                                state_reg <= ST_PUSHF;
                            end else begin
                                rowv_reg[tgt_reg] <= 1'b1;
                                state_reg         <= ST_FIN;
                            end
                        end
                    end
                    ST_PUSHF: begin
                        lpf_reg   <= item_reg.frame;
                        state_reg <= ST_FIN;
                    end
                    ST_SCAN_A: begin
                        timed_out_reg <= busy_i && (age_i > cfg.reasm_to);
                        prod_rcv_reg  <= frsm_pkg::PROD_W'(srcv_reg[idx_reg]) *
                                         frsm_pkg::PROD_W'(frsm_pkg::PERMILLE_FULL);
                        prod_len_reg  <= frsm_pkg::PROD_W'(cfg.permille) *
                                         frsm_pkg::PROD_W'(slen_reg[idx_reg]);
                        state_reg     <= ST_SCAN_B;
                    end
                    ST_SCAN_B: begin
                        if (timed_out_reg && part_ok) begin
                            lpf_reg <= frame_i;
                        end
                        idx_reg   <= idx_last ? '0 : idx_reg + 1'b1;
                        state_reg <= idx_last ? ST_FIN : ST_SCAN_A;
                    end
                    ST_FIN: begin
                        state_reg <= ST_IDLE;
                    end
                    default: begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/frsm_out.sv
// output register stage of the result stream
// depends on frsm_pkg
`default_nettype none

module frsm_out (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             push_valid,
    input  frsm_pkg::result_t                push_res,
    output logic                             push_ready,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [frsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [2:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    logic              valid_reg;
    frsm_pkg::result_t res_reg;

    assign push_ready    = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg.length, res_reg.offset, res_reg.frame, res_reg.slot};
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;

    // result holding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push_ready) begin
            valid_reg <= push_valid;
            if (push_valid) begin
                res_reg <= push_res;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/frame_reassembly_slot_manager_unit.sv
// Frame reassembly slot manager. A request is either a decoded packet header
// (tuser 0) or one tick (tuser 1); each request yields one to ten results,
// the final one flagged by tlast. The front end classifies a request and
// places it in a two-entry queue; the back end sequencer works through the
// slots one by one. A packet dropped by its header checks or as stale goes
// from dispatch to the final state; any other packet searches all slots, then
// chooses one, reads its section bitmap and emits. A resync first releases
// all busy slots; a tick checks each slot for a timeout. A result not taken
// downstream stalls the sequencer. The user must make configuration writes
// (cfg_wr_en/cfg_addr/cfg_wr_data) only while idle; the block does not check.
// depends on frsm_pkg, frsm_front, frsm_queue, frsm_back, frsm_out
`default_nettype none

module frame_reassembly_slot_manager_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // frame_index, section_index, frame_length, packet_length, buffer_available
    input  logic [frsm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cmd
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // slot_number, event_frame, write_offset, write_length
    output logic [frsm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // event_kind
    output logic [2:0]                           m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_wr_en,
    input  logic [frsm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [31:0]                          cfg_wr_data
);

    frsm_pkg::cfg_t    cfg_reg;
    frsm_pkg::item_t   f_item, q_item;
    logic              q_push, q_full, q_valid, q_pop;
    logic              push_valid, push_ready;
    frsm_pkg::result_t push_res;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.spb        <= 16'd1024;
            cfg_reg.large_thr  <= 21'd65536;
            cfg_reg.sync_to    <= 32'd1000;
            cfg_reg.reasm_to   <= 32'd200;
            cfg_reg.gap        <= -16'sd100;
            cfg_reg.allow_part <= 1'b0;
            cfg_reg.permille   <= 10'd900;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                frsm_pkg::CFG_SECTION_BYTES: cfg_reg.spb        <= cfg_wr_data[15:0];
                frsm_pkg::CFG_LARGE_THR:     cfg_reg.large_thr  <= cfg_wr_data[20:0];
                frsm_pkg::CFG_SYNC_TO:       cfg_reg.sync_to    <= cfg_wr_data;
                frsm_pkg::CFG_REASM_TO:      cfg_reg.reasm_to   <= cfg_wr_data;
                frsm_pkg::CFG_INDEX_GAP:     cfg_reg.gap        <= cfg_wr_data[15:0];
                frsm_pkg::CFG_ALLOW_PART:    cfg_reg.allow_part <= cfg_wr_data[0];
                frsm_pkg::CFG_PERMILLE:      cfg_reg.permille   <= cfg_wr_data[9:0];
                default:                     cfg_reg            <= cfg_reg;
            endcase
        end
    end

    frsm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (f_item)
    );

    frsm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (f_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_item)
    );

    frsm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .push_valid (push_valid),
        .push_res   (push_res),
        .push_ready (push_ready)
    );

    frsm_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push_valid    (push_valid),
        .push_res      (push_res),
        .push_ready    (push_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/core/frsm_checker.sv
// port-level checks on the result stream of the slot manager, bound to the top
// depends on frsm_pkg and frame_reassembly_slot_manager_unit_macros.svh
`default_nettype none
`include "frame_reassembly_slot_manager_unit_macros.svh"

module frsm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [frsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [2:0]                       m_axis_tuser,
    input logic                             m_axis_tlast
);

    // a stalled result holds
    `FRSM_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

    // an empty result stands alone, all zero, and ends the request
    `FRSM_ASSERT_SAME(a_none, m_axis_tvalid && m_axis_tuser == frsm_pkg::EV_NONE, m_axis_tlast && m_axis_tdata == '0, "empty result not last or not zero")

    // only a write carries offset and length
    `FRSM_ASSERT_SAME(a_nowrite, m_axis_tvalid && m_axis_tuser != frsm_pkg::EV_WRITE, m_axis_tdata[54:19] == 36'd0, "offset or length on non-write")

    // a write always moves bytes
    `FRSM_ASSERT_SAME(a_wlen, m_axis_tvalid && m_axis_tuser == frsm_pkg::EV_WRITE, m_axis_tdata[54:39] != 16'd0, "write of zero length")

endmodule

bind frame_reassembly_slot_manager_unit frsm_checker u_frsm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
